FILE: sv/bll_pkg.sv
// Shared types and constants for the bounded linked list engine.
`default_nettype none

package bll_pkg;

	localparam int CAPACITY   = 64;
	localparam int VALUE_BITS = 32;
	localparam int POS_W      = 7;
	localparam int SLOT_W     = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	typedef enum logic [1:0] {
		K_INSERT = 2'd0,
		K_REMOVE = 2'd1,
		K_SEARCH = 2'd2,
		K_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_IGNORED = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_POP,
		S_ALLOC,
		S_INS_TAIL,
		S_WALK,
		S_INS_LINK,
		S_INS_LINK2,
		S_REM_LINK,
		S_PUSH,
		S_SEARCH
	} state_t;

endpackage

`default_nettype wire

FILE: sv/bll_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module bll_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: sv/bounded_linked_list_engine.sv
// Top level of the bounded linked list engine: sequencer, list registers, slot stores.
//
// Usage: drive kind, position, from_tail and value and raise start while busy is
// low; the word is taken at that clock edge and busy goes high the next cycle.
// Exactly one result word comes back per command: done is high for one cycle
// with found, count and status valid in that cycle. busy is already low in the
// done cycle, so the next command may be started there.
// A walk visits one link per cycle on the shared read port of the value and link
// stores. Clear, an insert into a full list and an ignored remove finish straight
// from decode; an insert into an empty list or at the front writes its slot after
// the pop; an insert at the end also relinks the tail; an insert at position p
// walks to the predecessor and relinks twice; a remove walks to its predecessor
// unless at 0 or of the only entry; a search walks until a match or the end.
// Reset (arst_n low) empties the list at once; there is no clearing pass, the
// free-slot stack is tracked by a low-water mark. The receiver cannot stall.
`default_nettype none

module bounded_linked_list_engine
	import bll_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [1:0]            kind,
	input  wire logic [POS_W-1:0]      position,
	input  wire logic                  from_tail,
	input  wire logic [VALUE_BITS-1:0] value,
	output logic                       done,
	output logic                       found,
	output logic      [CNT_W-1:0]      count,
	output logic      [1:0]            status
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q, count_d;
	logic [SLOT_W-1:0] head_q, head_d;
	logic [SLOT_W-1:0] tail_q, tail_d;
	logic [CNT_W-1:0]  min_top_q, min_top_d;
	logic              done_q, done_d;

	kind_t             kind_q, kind_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic              from_tail_q, from_tail_d;
	logic [VALUE_BITS-1:0] value_q, value_d;
	logic              last_q, last_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [SLOT_W-1:0] cur_q, cur_d;
	logic [SLOT_W-1:0] slot_q, slot_d;
	logic              found_q, found_d;
	status_t           status_q, status_d;

	logic [SLOT_W-1:0] rd_addr;
	logic [VALUE_BITS-1:0] val_rd;
	logic [SLOT_W-1:0] link_rd;
	logic              link_we;
	logic [SLOT_W-1:0] link_waddr;
	logic [SLOT_W-1:0] link_wdata;
	logic              val_we;
	logic              free_we;
	logic [SLOT_W-1:0] free_waddr;
	logic [SLOT_W-1:0] free_raddr;
	logic [SLOT_W-1:0] free_rd;

	logic [CMP_W-1:0]  pos_ext;
	logic [CMP_W-1:0]  cnt_ext;
	logic [CMP_W-1:0]  pos_eff;
	logic [CMP_W-1:0]  cnt_m1;

	assign pos_ext    = CMP_W'(pos_q);
	assign cnt_ext    = CMP_W'(count_q);
	assign cnt_m1     = cnt_ext - CMP_W'(1);
	assign pos_eff    = from_tail_q ? cnt_m1 : pos_ext;
	// stack top (pop) is CAPACITY - 1 - count, push slot is CAPACITY - count
	assign free_raddr = SLOT_W'(CAP_CNT - CNT_W'(1) - count_q);
	assign free_waddr = SLOT_W'(CAP_CNT - count_q);

	bll_ram #(.DEPTH(CAPACITY), .WIDTH(VALUE_BITS)) u_values (
		.clk   (clk),
		.we    (val_we),
		.waddr (slot_q),
		.wdata (value_q),
		.raddr (rd_addr),
		.rdata (val_rd)
	);

	bll_ram #(.DEPTH(CAPACITY), .WIDTH(SLOT_W)) u_links (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (rd_addr),
		.rdata (link_rd)
	);

	bll_ram #(.DEPTH(CAPACITY), .WIDTH(SLOT_W)) u_free (
		.clk   (clk),
		.we    (free_we),
		.waddr (free_waddr),
		.wdata (slot_q),
		.raddr (free_raddr),
		.rdata (free_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			min_top_q <= CAP_CNT;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			min_top_q <= min_top_d;
			done_q    <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q      <= kind_d;
		pos_q       <= pos_d;
		from_tail_q <= from_tail_d;
		value_q     <= value_d;
		last_q      <= last_d;
		cnt_q       <= cnt_d;
		cur_q       <= cur_d;
		slot_q      <= slot_d;
		found_q     <= found_d;
		status_q    <= status_d;
	end

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		head_d      = head_q;
		tail_d      = tail_q;
		min_top_d   = min_top_q;
		done_d      = 1'b0;
		kind_d      = kind_q;
		pos_d       = pos_q;
		from_tail_d = from_tail_q;
		value_d     = value_q;
		last_d      = last_q;
		cnt_d       = cnt_q;
		cur_d       = cur_q;
		slot_d      = slot_q;
		found_d     = found_q;
		status_d    = status_q;
		rd_addr     = cur_q;
		link_we     = 1'b0;
		link_waddr  = slot_q;
		link_wdata  = '0;
		val_we      = 1'b0;
		free_we     = 1'b0;

		case (state_q)
			S_IDLE: begin
				rd_addr = head_q;
				cur_d   = head_q;
				if (start) begin
					kind_d      = kind_t'(kind);
					pos_d       = position;
					from_tail_d = from_tail;
					value_d     = value;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				case (kind_q)
					K_INSERT: begin
						if (count_q == CAP_CNT) begin
							done_d   = 1'b1;
							found_d  = 1'b0;
							status_d = ST_FULL;
							state_d  = S_IDLE;
						end else begin
							state_d = S_POP;
						end
					end
					K_REMOVE: begin
						last_d = (pos_eff == cnt_m1);
						if (count_q == '0 || pos_eff >= cnt_ext) begin
							done_d   = 1'b1;
							found_d  = 1'b0;
							status_d = ST_IGNORED;
							state_d  = S_IDLE;
						end else if (count_q == CNT_W'(1)) begin
							slot_d  = head_q;
							head_d  = '0;
							tail_d  = '0;
							state_d = S_PUSH;
						end else if (pos_eff == '0) begin
							slot_d  = head_q;
							head_d  = link_rd;
							state_d = S_PUSH;
						end else begin
							cnt_d   = CNT_W'(pos_eff - CMP_W'(1));
							state_d = S_WALK;
						end
					end
					K_SEARCH: begin
						cnt_d   = count_q;
						state_d = S_SEARCH;
					end
					default: begin
						count_d   = '0;
						head_d    = '0;
						tail_d    = '0;
						min_top_d = CAP_CNT;
						done_d    = 1'b1;
						found_d   = 1'b0;
						status_d  = ST_DONE;
						state_d   = S_IDLE;
					end
				endcase
			end
			S_POP: begin
				// slots below the low-water mark were never pushed: identity
				if (CNT_W'(free_raddr) < min_top_q) begin
					slot_d    = free_raddr;
					min_top_d = CNT_W'(free_raddr);
				end else begin
					slot_d = free_rd;
				end
				state_d = S_ALLOC;
			end
			S_ALLOC: begin
				val_we  = 1'b1;
				link_we = 1'b1;
				if (count_q == '0) begin
					head_d   = slot_q;
					tail_d   = slot_q;
					count_d  = count_q + CNT_W'(1);
					done_d   = 1'b1;
					found_d  = 1'b0;
					status_d = ST_DONE;
					state_d  = S_IDLE;
				end else if (!from_tail_q && pos_q == '0) begin
					link_wdata = head_q;
					head_d     = slot_q;
					count_d    = count_q + CNT_W'(1);
					done_d     = 1'b1;
					found_d    = 1'b0;
					status_d   = ST_DONE;
					state_d    = S_IDLE;
				end else if (from_tail_q || pos_ext >= cnt_ext) begin
					state_d = S_INS_TAIL;
				end else begin
					link_we = 1'b0;
					cnt_d   = CNT_W'(pos_ext - CMP_W'(1));
					state_d = S_WALK;
				end
			end
			S_INS_TAIL: begin
				link_we    = 1'b1;
				link_waddr = tail_q;
				link_wdata = slot_q;
				tail_d     = slot_q;
				count_d    = count_q + CNT_W'(1);
				done_d     = 1'b1;
				found_d    = 1'b0;
				status_d   = ST_DONE;
				state_d    = S_IDLE;
			end
			S_WALK: begin
				if (cnt_q == '0) begin
					// cur_q is the predecessor, link_rd its successor
					if (kind_q == K_INSERT) begin
						state_d = S_INS_LINK;
					end else begin
						slot_d = link_rd;
						if (last_q) begin
							link_we    = 1'b1;
							link_waddr = cur_q;
							link_wdata = '0;
							tail_d     = cur_q;
							state_d    = S_PUSH;
						end else begin
							rd_addr = link_rd;
							state_d = S_REM_LINK;
						end
					end
				end else begin
					cur_d   = link_rd;
					rd_addr = link_rd;
					cnt_d   = cnt_q - CNT_W'(1);
				end
			end
			S_INS_LINK: begin
				link_we    = 1'b1;
				link_waddr = slot_q;
				link_wdata = link_rd;
				state_d    = S_INS_LINK2;
			end
			S_INS_LINK2: begin
				link_we    = 1'b1;
				link_waddr = cur_q;
				link_wdata = slot_q;
				count_d    = count_q + CNT_W'(1);
				done_d     = 1'b1;
				found_d    = 1'b0;
				status_d   = ST_DONE;
				state_d    = S_IDLE;
			end
			S_REM_LINK: begin
				link_we    = 1'b1;
				link_waddr = cur_q;
				link_wdata = link_rd;
				state_d    = S_PUSH;
			end
			S_PUSH: begin
				free_we  = 1'b1;
				count_d  = count_q - CNT_W'(1);
				done_d   = 1'b1;
				found_d  = 1'b0;
				status_d = ST_DONE;
				state_d  = S_IDLE;
			end
			S_SEARCH: begin
				if (cnt_q == '0) begin
					done_d   = 1'b1;
					found_d  = 1'b0;
					status_d = ST_DONE;
					state_d  = S_IDLE;
				end else if (val_rd == value_q) begin
					done_d   = 1'b1;
					found_d  = 1'b1;
					status_d = ST_DONE;
					state_d  = S_IDLE;
				end else if (cnt_q == CNT_W'(1)) begin
					done_d   = 1'b1;
					found_d  = 1'b0;
					status_d = ST_DONE;
					state_d  = S_IDLE;
				end else begin
					cur_d   = link_rd;
					rd_addr = link_rd;
					cnt_d   = cnt_q - CNT_W'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign found  = found_q;
	assign count  = count_q;
	assign status = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("entry count above capacity");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> head_q == '0 && tail_q == '0)
		else $error("empty list with nonzero head or tail");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q == ST_FULL |-> count_q == CAP_CNT)
		else $error("full status on a list with free slots");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result word held for more than one cycle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done_q)
		else $error("accepted command did not raise busy");

endmodule

`default_nettype wire
